@@ src/vnn_pkg.sv @@
package vnn_pkg;

  localparam int unsigned CompW = 32;
  localparam int unsigned SumW = 64;
  localparam int unsigned SqrtStages = 32;
  localparam int unsigned FracShift = 30;
  // numerator of a unit division is mag << 30, 62 bits wide at most
  localparam int unsigned DivStages = CompW + FracShift;
  localparam logic [CompW-1:0] OneQ230 = 32'h4000_0000;

  // magnitudes and signs carried alongside the arithmetic
  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][CompW-1:0] mag;
  } vnn_side_t;

endpackage

@@ src/vnn_square.sv @@
module vnn_square (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [2:0][31:0]         comp,
  output logic                     out_valid,
  output logic [vnn_pkg::SumW-1:0] sum,
  output vnn_pkg::vnn_side_t       side
);

  logic                    v1, v2;
  vnn_pkg::vnn_side_t      side1, side2;
  logic [2:0][63:0]        sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  // stage 1: magnitudes, stage 2: squares, stage 3: sum modulo 2^64
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      side1.neg[k] <= comp[k][31];
      side1.mag[k] <= comp[k][31] ? (~comp[k] + 32'd1) : comp[k];
      sq[k] <= side1.mag[k] * side1.mag[k];
    end
    side2 <= side1;
    side  <= side2;
    sum   <= sq[0] + sq[1] + sq[2];
  end

endmodule

@@ src/vnn_isqrt.sv @@
module vnn_isqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [vnn_pkg::SumW-1:0] sum,
  input  vnn_pkg::vnn_side_t       in_side,
  output logic                     out_valid,
  output logic [31:0]              root,
  output vnn_pkg::vnn_side_t       out_side
);

  localparam int unsigned NS = vnn_pkg::SqrtStages;

  logic [63:0]        rem [0:NS];
  logic [63:0]        res [0:NS];
  logic               vld [0:NS];
  vnn_pkg::vnn_side_t sd  [0:NS];

  assign rem[0] = sum;
  assign res[0] = 64'd0;
  assign vld[0] = in_valid;
  assign sd[0]  = in_side;

  // one result bit per stage
  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * i);
    logic [63:0] trial;
    assign trial = res[i] + Bit;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      sd[i+1] <= sd[i];
      if (rem[i] >= trial) begin
        rem[i+1] <= rem[i] - trial;
        res[i+1] <= (res[i] >> 1) + Bit;
      end else begin
        rem[i+1] <= rem[i];
        res[i+1] <= res[i] >> 1;
      end
    end
  end

  assign out_valid = vld[NS];
  assign root      = res[NS][31:0];
  assign out_side  = sd[NS];

  a_root_fits: assert property (@(posedge clk) disable iff (rst)
    vld[NS] |-> res[NS][63:32] == 32'd0)
    else $error("square root wider than 32 bits");

endmodule

@@ src/vnn_divide.sv @@
module vnn_divide (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [31:0]        len,
  input  vnn_pkg::vnn_side_t in_side,
  output logic               out_valid,
  output logic [31:0]        out_len,
  output logic [2:0][31:0]   quot,
  output logic [2:0]         out_neg
);

  localparam int unsigned ND = vnn_pkg::DivStages;
  localparam int unsigned FS = vnn_pkg::FracShift;

  logic                vld [0:ND];
  logic [31:0]         dv  [0:ND];
  vnn_pkg::vnn_side_t  sd  [0:ND];
  logic [2:0][31:0]    rm  [0:ND];
  logic [2:0][31:0]    q   [0:ND];

  assign vld[0] = in_valid;
  assign dv[0]  = len;
  assign sd[0]  = in_side;
  assign rm[0]  = '0;
  assign q[0]   = '0;

  // restoring division, one quotient bit per stage, three lanes
  for (genvar i = 0; i < ND; i++) begin : g_stage
    localparam int NumBit = ND - 1 - i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic        nb;
      logic [32:0] t;
      if (NumBit >= FS) begin : g_mag
        assign nb = sd[i].mag[k][NumBit - FS];
      end else begin : g_zero
        assign nb = 1'b0;
      end
      assign t = {rm[i][k], nb};

      always_ff @(posedge clk) begin
        if (t >= {1'b0, dv[i]}) begin
          rm[i+1][k] <= 32'(t - {1'b0, dv[i]});
          q[i+1][k]  <= {q[i][k][30:0], 1'b1};
        end else begin
          rm[i+1][k] <= t[31:0];
          q[i+1][k]  <= {q[i][k][30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      dv[i+1] <= dv[i];
      sd[i+1] <= sd[i];
    end
  end

  assign out_valid = vld[ND];
  assign out_len   = dv[ND];
  assign quot      = q[ND];
  assign out_neg   = sd[ND].neg;

  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    vld[ND] && dv[ND] != 32'd0 && sd[ND].mag[0] <= dv[ND] |-> q[ND][0] <= vnn_pkg::OneQ230)
    else $error("unit component above one");

endmodule

@@ src/vector3_norm_normalize_top.sv @@
// throughput: one vector per cycle; busy is always low
// latency comes from the squaring stages, the 32-stage square root, the 62-stage divider lanes and the output register
// reset: synchronous, active high; clears all valid bits, threshold back to 1
// the receiver cannot stall: each result stands for one cycle with done
module vector3_norm_normalize_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] comp_x,
  input  logic signed [31:0] comp_y,
  input  logic signed [31:0] comp_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic [31:0]        length,
  output logic signed [31:0] unit_x,
  output logic signed [31:0] unit_y,
  output logic signed [31:0] unit_z,
  output logic               too_small
);

  logic [31:0] small_threshold;

  logic                  sq_valid;
  logic [63:0]           sq_sum;
  vnn_pkg::vnn_side_t    sq_side;
  logic                  rt_valid;
  logic [31:0]           rt_root;
  vnn_pkg::vnn_side_t    rt_side;
  logic                  dv_valid;
  logic [31:0]           dv_len;
  logic [2:0][31:0]      dv_quot;
  logic [2:0]            dv_neg;
  logic                  force_unit;
  logic [2:0][31:0]      signed_q;

  // fully pipelined, never holds off a transfer
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      small_threshold <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      small_threshold <= cfg_data;
    end
  end

  // magnitudes, squares and the sum of squares
  vnn_square u_square (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .comp      ({comp_z, comp_y, comp_x}),
    .out_valid (sq_valid),
    .sum       (sq_sum),
    .side      (sq_side)
  );

  // exact integer square root gives the truncated length
  vnn_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .sum       (sq_sum),
    .in_side   (sq_side),
    .out_valid (rt_valid),
    .root      (rt_root),
    .out_side  (rt_side)
  );

  // each magnitude times 2^30 over the length
  vnn_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rt_valid),
    .len       (rt_root),
    .in_side   (rt_side),
    .out_valid (dv_valid),
    .out_len   (dv_len),
    .quot      (dv_quot),
    .out_neg   (dv_neg)
  );

  // threshold compare uses the live register; the user makes config changes only while idle, unchecked by the block
  assign force_unit = (dv_len == 32'd0) || (dv_len < small_threshold);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      signed_q[k] = dv_neg[k] ? (32'd0 - dv_quot[k]) : dv_quot[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
  end

  // output register for each result
  always_ff @(posedge clk) begin
    length    <= dv_len;
    too_small <= force_unit;
    if (force_unit) begin
      unit_x <= vnn_pkg::OneQ230;
      unit_y <= 32'sd0;
      unit_z <= 32'sd0;
    end else begin
      unit_x <= signed_q[0];
      unit_y <= signed_q[1];
      unit_z <= signed_q[2];
    end
  end

  a_not_small_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && !too_small |-> length != 32'd0)
    else $error("normalised a zero length");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  // ---------------------------------------------------------------------------
  // expected result of one vector
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [31:0] len;
    logic [31:0] ux;
    logic [31:0] uy;
    logic [31:0] uz;
    logic        flag;
  } norm_res_t;

  // ---------------------------------------------------------------------------
  // scoreboard: predicts length and unit vector, holds pending results
  // ---------------------------------------------------------------------------
  class norm_scoreboard;
    norm_res_t   pending[$];
    logic [31:0] threshold;
    int          errors;

    function new();
      threshold = 32'd1;
      errors = 0;
    endfunction

    function logic [63:0] root64(logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] b;
      rem = v;
      res = 0;
      b = 64'd1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
        if (rem >= res + b) begin
          rem = rem - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function logic [31:0] scaled(logic [31:0] c, logic [31:0] len);
      logic [63:0] mag;
      logic [63:0] q;
      mag = c[31] ? {32'd0, (~c) + 32'd1} : {32'd0, c};
      q = (mag << 30) / {32'd0, len};
      if (c[31]) q = -q;
      return q[31:0];
    endfunction

    function void note_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      logic [63:0] mx;
      logic [63:0] my;
      logic [63:0] mz;
      norm_res_t   r;
      mx = x[31] ? {32'd0, (~x) + 32'd1} : {32'd0, x};
      my = y[31] ? {32'd0, (~y) + 32'd1} : {32'd0, y};
      mz = z[31] ? {32'd0, (~z) + 32'd1} : {32'd0, z};
      r.len = root64(mx * mx + my * my + mz * mz);
      if (r.len == 0 || r.len < threshold) begin
        r.ux = vnn_pkg::OneQ230;
        r.uy = 0;
        r.uz = 0;
        r.flag = 1'b1;
      end else begin
        r.ux = scaled(x, r.len);
        r.uy = scaled(y, r.len);
        r.uz = scaled(z, r.len);
        r.flag = 1'b0;
      end
      pending.push_back(r);
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endfunction

    function void check_result(norm_res_t got);
      norm_res_t want;
      if (pending.size() == 0) begin
        $display("mismatch: result with nothing pending");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.len !== want.len) report("length", got.len, want.len);
      if (got.ux !== want.ux) report("unit_x", got.ux, want.ux);
      if (got.uy !== want.uy) report("unit_y", got.uy, want.uy);
      if (got.uz !== want.uz) report("unit_z", got.uz, want.uz);
      if (got.flag !== want.flag) report("too_small", {31'd0, got.flag}, {31'd0, want.flag});
    endfunction
  endclass

  localparam int Latency = 98;
  localparam int IdleLimit = 5000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [31:0] comp_x;
  logic signed [31:0] comp_y;
  logic signed [31:0] comp_z;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [31:0]        cfg_data;
  logic               done;
  logic [31:0]        length;
  logic signed [31:0] unit_x;
  logic signed [31:0] unit_y;
  logic signed [31:0] unit_z;
  logic               too_small;

  norm_scoreboard sb;
  int             idle_cycles;

  vector3_norm_normalize_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .length(length), .unit_x(unit_x), .unit_y(unit_y),
    .unit_z(unit_z), .too_small(too_small)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // results are sampled at the edge that ends their cycle; the receiver never stalls
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result({length, unit_x, unit_y, unit_z, too_small});
    end
  end

  // watchdog: counts cycles with no transfer of any kind
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("vector3_norm_normalize_top test failed");
        $finish;
      end
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // a gap drops start first so the last vector is not sent again
  task automatic idle_cycles_for(int n);
    if (n > 0) start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // one vector transfer: start held until an edge sees busy low
  task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    start  <= 1'b1;
    comp_x <= x;
    comp_y <= y;
    comp_z <= z;
    do @(posedge clk); while (busy);
    sb.note_vector(x, y, z);
  endtask

  // threshold write, only once the pipe has drained
  task automatic write_threshold(logic [31:0] value);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    idle_cycles_for(4);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.threshold = value;
  endtask

  // component biased towards small, edge and full-range values
  function automatic logic [31:0] rand_comp(int scale);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 32'h8000_0000;
    if (sel == 1) return 32'h7fff_ffff;
    if (sel < 5) return $urandom();
    return $urandom() >> scale;
  endfunction

  task automatic random_phase(int n);
    int sc;
    for (int i = 0; i < n; i++) begin
      sc = $urandom_range(0, 31);
      send_vector(rand_comp(sc), rand_comp(sc), rand_comp(sc));
      // a stretch of back-to-back transfers now and then
      if ((i % 64) < 48) idle_cycles_for(gap_len());
    end
  endtask

  initial begin
    sb = new();
    idle_cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    comp_x = '0;
    comp_y = '0;
    comp_z = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero, tiny, extremes, signs, most negative component
    send_vector(32'd0, 32'd0, 32'd0);
    send_vector(32'd1, 32'd0, 32'd0);
    send_vector(32'd0, 32'hffff_ffff, 32'd0);
    send_vector(32'd0, 32'd0, 32'd2);
    send_vector(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_vector(32'hffff_0000, 32'h0002_0000, 32'hfffe_0000);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vector(32'h8000_0000, 32'd0, 32'd0);
    send_vector(32'h7fff_ffff, 32'h8000_0000, 32'd1);
    send_vector(32'd3, 32'd4, 32'd0);
    send_vector(32'hffff_fffd, 32'hffff_fffc, 32'hffff_ffff);

    // zero threshold: only the zero vector is forced
    write_threshold(32'd0);
    send_vector(32'd0, 32'd0, 32'd0);
    send_vector(32'd1, 32'd0, 32'd0);
    send_vector(32'hffff_ffff, 32'd0, 32'd0);
    // largest threshold: every vector is too small
    write_threshold(32'hffff_ffff);
    send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(32'h0001_0000, 32'd0, 32'd0);
    // threshold of 2^16 with lengths just below it and equal to it
    write_threshold(32'h0001_0000);
    send_vector(32'h0000_ffff, 32'd0, 32'd0);
    send_vector(32'h0001_0000, 32'd0, 32'd0);
    send_vector(32'd0, 32'h0000_b505, 32'h0000_b505);

    // random phases through several thresholds
    write_threshold(32'd1);
    random_phase(150);
    write_threshold(32'h0010_0000);
    random_phase(130);
    write_threshold(32'd0);
    random_phase(130);
    write_threshold($urandom());
    random_phase(120);

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    idle_cycles_for(Latency + 10);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("vector3_norm_normalize_top test passed");
    end else begin
      $display("vector3_norm_normalize_top test failed");
    end
    $finish;
  end

endmodule
